[rtl/assert_macros.svh]
// assertion macros shared by the rtl of the index remap table
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define IRT_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is active
`define IRT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/irt_pkg.sv]
// types and constants of the index remap table
// no dependencies; used by index_remap_table
package irt_pkg;

    localparam int IDX_W         = 10;
    localparam int MAP_W         = 11;
    localparam int EXT_W         = 11;
    localparam int IDX_RANGE     = 1 << IDX_W;
    localparam int MAP_DEPTH_DEF = 1024;
    localparam int S_TDATA_W     = 40;
    localparam int M_TDATA_W     = 16;

    localparam logic [MAP_W-1:0] UNMAPPED = '1;

    typedef enum logic [2:0] {
        OP_ADD       = 3'd0,
        OP_LOOKUP    = 3'd1,
        OP_HAS       = 3'd2,
        OP_SWAP      = 3'd3,
        OP_OVERWRITE = 3'd4,
        OP_CHECK     = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_RANGE    = 2'd1,
        STAT_CONFLICT = 2'd2,
        STAT_UNMAPPED = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_EXEC,
        ST_SWAP_WB,
        ST_CHK_START,
        ST_CHK_CLR,
        ST_CHK_RD,
        ST_CHK_VAL,
        ST_CHK_MARK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             is_permutation;
        status_t          status;
        logic             present;
        logic [IDX_W-1:0] mapped_value;
    } res_t;

endpackage

[rtl/index_remap_table.sv]
// index remap table top level: row and column old-to-new maps with sequencer
// depends on irt_pkg and assert_macros.svh
//
// Holds two old-to-new index maps (rows, columns) in one single-port-write
// memory and serves one command at a time. After reset the block clears the
// map memory and accepts no transfer until that is done. Then add, lookup,
// has and overwrite go from the accepted transfer through ST_RD_A, ST_EXEC
// and ST_DONE to the result; swap adds ST_RD_B and ST_SWAP_WB, as each map
// entry takes one registered read and the memory has one write port. A
// permutation check walks both maps through the same read port and a marker
// memory, and stops early when it fails. The result sits in an output
// register, so the next transfer is accepted while a result still waits on
// m_tready.
`include "assert_macros.svh"

module index_remap_table #(
    parameter int MAP_DEPTH = irt_pkg::MAP_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // opcode[2:0], index_a[12:3], other_index[22:13], new_number[32:23], zeros
    input  logic [irt_pkg::S_TDATA_W-1:0]  s_tdata,
    // table_sel[0]
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // mapped_value[9:0], present[10], status[12:11], is_permutation[13], zeros
    output logic [irt_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int ADDR_W    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int MADDR_W   = ADDR_W + 1;
    localparam int MEM_DEPTH = 1 << MADDR_W;
    localparam int EXT_LIMIT = (MAP_DEPTH < irt_pkg::IDX_RANGE) ? MAP_DEPTH
                                                               : irt_pkg::IDX_RANGE;

    // storage
    logic [irt_pkg::MAP_W-1:0] map_mem  [MEM_DEPTH];
    logic                      mark_mem [MAP_DEPTH];

    // control registers
    irt_pkg::state_t            state_reg, state_next;
    logic [irt_pkg::EXT_W-1:0]  row_ext_reg, row_ext_next;
    logic [irt_pkg::EXT_W-1:0]  col_ext_reg, col_ext_next;
    logic [MADDR_W-1:0]         clr_reg, clr_next;
    logic [irt_pkg::EXT_W-1:0]  idx_reg, idx_next;
    logic                       chk_sel_reg, chk_sel_next;
    logic                       m_valid_reg, m_valid_next;

    // payload registers
    irt_pkg::op_t               op_reg, op_next;
    logic                       sel_reg, sel_next;
    logic [irt_pkg::IDX_W-1:0]  a_reg, a_next;
    logic [irt_pkg::IDX_W-1:0]  b_reg, b_next;
    logic [irt_pkg::IDX_W-1:0]  nn_reg, nn_next;
    logic [irt_pkg::MAP_W-1:0]  va_reg, va_next;
    logic [ADDR_W-1:0]          val_reg, val_next;
    irt_pkg::res_t              res_reg, res_next;
    irt_pkg::res_t              m_data_reg, m_data_next;

    // memory ports
    logic                       map_we;
    logic [MADDR_W-1:0]         map_waddr, map_raddr;
    logic [irt_pkg::MAP_W-1:0]  map_wdata;
    logic [irt_pkg::MAP_W-1:0]  map_rd_reg;
    logic                       mark_we;
    logic [ADDR_W-1:0]          mark_waddr, mark_raddr;
    logic                       mark_wdata;
    logic                       mark_rd_reg;

    // derived values
    logic [irt_pkg::EXT_W-1:0]  cur_ext, chk_ext, a_ext, b_ext;
    logic                       a_out, b_out, chk_last, out_free, swap_ok;

    assign cur_ext  = sel_reg ? col_ext_reg : row_ext_reg;
    assign chk_ext  = chk_sel_reg ? col_ext_reg : row_ext_reg;
    assign a_ext    = {1'b0, a_reg};
    assign b_ext    = {1'b0, b_reg};
    assign a_out    = a_ext >= cur_ext;
    assign b_out    = b_ext >= cur_ext;
    assign chk_last = idx_reg == (chk_ext - irt_pkg::EXT_W'(1));
    assign out_free = !m_valid_reg || m_tready;
    assign swap_ok  = !a_out && !b_out && (va_reg != irt_pkg::UNMAPPED)
                      && (map_rd_reg != irt_pkg::UNMAPPED);

    assign s_tready = state_reg == irt_pkg::ST_IDLE;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_data_reg};

    // map memory
    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_rd_reg <= map_mem[map_raddr];
    end

    // marker memory
    always_ff @(posedge aclk) begin
        if (mark_we) begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        mark_rd_reg <= mark_mem[mark_raddr];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            irt_pkg::ST_INIT: begin
                if (&clr_reg) begin
                    state_next = irt_pkg::ST_IDLE;
                end
            end
            irt_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = irt_pkg::ST_RD_A;
                end
            end
            irt_pkg::ST_RD_A: begin
                if (op_reg == irt_pkg::OP_CHECK) begin
                    state_next = irt_pkg::ST_CHK_START;
                end else if (op_reg == irt_pkg::OP_SWAP) begin
                    state_next = irt_pkg::ST_RD_B;
                end else begin
                    state_next = irt_pkg::ST_EXEC;
                end
            end
            irt_pkg::ST_RD_B: begin
                state_next = irt_pkg::ST_EXEC;
            end
            irt_pkg::ST_EXEC: begin
                if (op_reg == irt_pkg::OP_SWAP && swap_ok) begin
                    state_next = irt_pkg::ST_SWAP_WB;
                end else begin
                    state_next = irt_pkg::ST_DONE;
                end
            end
            irt_pkg::ST_SWAP_WB: begin
                state_next = irt_pkg::ST_DONE;
            end
            irt_pkg::ST_CHK_START: begin
                if (chk_ext == '0) begin
                    state_next = irt_pkg::ST_DONE;
                end else begin
                    state_next = irt_pkg::ST_CHK_CLR;
                end
            end
            irt_pkg::ST_CHK_CLR: begin
                if (chk_last) begin
                    state_next = irt_pkg::ST_CHK_RD;
                end
            end
            irt_pkg::ST_CHK_RD: begin
                state_next = irt_pkg::ST_CHK_VAL;
            end
            irt_pkg::ST_CHK_VAL: begin
                if (map_rd_reg >= chk_ext) begin
                    state_next = irt_pkg::ST_DONE;
                end else begin
                    state_next = irt_pkg::ST_CHK_MARK;
                end
            end
            irt_pkg::ST_CHK_MARK: begin
                if (mark_rd_reg) begin
                    state_next = irt_pkg::ST_DONE;
                end else if (!chk_last) begin
                    state_next = irt_pkg::ST_CHK_RD;
                end else if (chk_sel_reg) begin
                    state_next = irt_pkg::ST_DONE;
                end else begin
                    state_next = irt_pkg::ST_CHK_START;
                end
            end
            irt_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = irt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = irt_pkg::ST_INIT;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        row_ext_next = row_ext_reg;
        col_ext_next = col_ext_reg;
        clr_next     = clr_reg;
        idx_next     = idx_reg;
        chk_sel_next = chk_sel_reg;
        m_valid_next = m_valid_reg;
        op_next      = op_reg;
        sel_next     = sel_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        nn_next      = nn_reg;
        va_next      = va_reg;
        val_next     = val_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        map_we       = 1'b0;
        map_waddr    = {sel_reg, ADDR_W'(a_reg)};
        map_wdata    = {1'b0, nn_reg};
        map_raddr    = {sel_reg, ADDR_W'(a_reg)};
        mark_we      = 1'b0;
        mark_waddr   = ADDR_W'(idx_reg);
        mark_wdata   = 1'b0;
        mark_raddr   = ADDR_W'(map_rd_reg);

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            irt_pkg::ST_INIT: begin
                map_we    = 1'b1;
                map_waddr = clr_reg;
                map_wdata = irt_pkg::UNMAPPED;
                clr_next  = clr_reg + MADDR_W'(1);
            end
            irt_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    op_next      = irt_pkg::op_t'(s_tdata[2:0]);
                    a_next       = s_tdata[12:3];
                    b_next       = s_tdata[22:13];
                    nn_next      = s_tdata[32:23];
                    sel_next     = s_tuser;
                    res_next     = '0;
                    chk_sel_next = 1'b0;
                end
            end
            irt_pkg::ST_RD_A: begin
                idx_next = '0;
            end
            irt_pkg::ST_RD_B: begin
                map_raddr = {sel_reg, ADDR_W'(b_reg)};
                va_next   = map_rd_reg;
            end
            irt_pkg::ST_EXEC: begin
                case (op_reg)
                    irt_pkg::OP_ADD: begin
                        if (32'(a_reg) >= 32'(MAP_DEPTH)) begin
                            res_next.status = irt_pkg::STAT_RANGE;
                        end else begin
                            if (a_out) begin
                                if (sel_reg) begin
                                    col_ext_next = a_ext + irt_pkg::EXT_W'(1);
                                end else begin
                                    row_ext_next = a_ext + irt_pkg::EXT_W'(1);
                                end
                            end
                            if (map_rd_reg != irt_pkg::UNMAPPED
                                && map_rd_reg != {1'b0, nn_reg}) begin
                                res_next.status = irt_pkg::STAT_CONFLICT;
                            end else begin
                                map_we = 1'b1;
                            end
                        end
                    end
                    irt_pkg::OP_LOOKUP: begin
                        if (a_out) begin
                            res_next.status = irt_pkg::STAT_RANGE;
                        end else if (map_rd_reg == irt_pkg::UNMAPPED) begin
                            res_next.status = irt_pkg::STAT_UNMAPPED;
                        end else begin
                            res_next.mapped_value = map_rd_reg[irt_pkg::IDX_W-1:0];
                            res_next.present      = 1'b1;
                        end
                    end
                    irt_pkg::OP_HAS: begin
                        if (a_out) begin
                            res_next.status = irt_pkg::STAT_RANGE;
                        end else begin
                            res_next.present = map_rd_reg != irt_pkg::UNMAPPED;
                        end
                    end
                    irt_pkg::OP_SWAP: begin
                        if (a_out || b_out) begin
                            res_next.status = irt_pkg::STAT_RANGE;
                        end else if (!swap_ok) begin
                            res_next.status = irt_pkg::STAT_UNMAPPED;
                        end else begin
                            map_we    = 1'b1;
                            map_wdata = map_rd_reg;
                        end
                    end
                    irt_pkg::OP_OVERWRITE: begin
                        if (a_out) begin
                            res_next.status = irt_pkg::STAT_RANGE;
                        end else begin
                            map_we = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            irt_pkg::ST_SWAP_WB: begin
                map_we    = 1'b1;
                map_waddr = {sel_reg, ADDR_W'(b_reg)};
                map_wdata = va_reg;
            end
            irt_pkg::ST_CHK_START: begin
                idx_next = '0;
            end
            irt_pkg::ST_CHK_CLR: begin
                mark_we = 1'b1;
                if (chk_last) begin
                    idx_next = '0;
                end else begin
                    idx_next = idx_reg + irt_pkg::EXT_W'(1);
                end
            end
            irt_pkg::ST_CHK_RD: begin
                map_raddr = {chk_sel_reg, ADDR_W'(idx_reg)};
            end
            irt_pkg::ST_CHK_VAL: begin
                val_next = ADDR_W'(map_rd_reg);
            end
            irt_pkg::ST_CHK_MARK: begin
                if (!mark_rd_reg) begin
                    mark_we    = 1'b1;
                    mark_waddr = val_reg;
                    mark_wdata = 1'b1;
                    idx_next   = idx_reg + irt_pkg::EXT_W'(1);
                    if (chk_last) begin
                        if (chk_sel_reg) begin
                            res_next.is_permutation = 1'b1;
                        end else begin
                            chk_sel_next = 1'b1;
                        end
                    end
                end
            end
            irt_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= irt_pkg::ST_INIT;
            row_ext_reg <= '0;
            col_ext_reg <= '0;
            clr_reg     <= '0;
            idx_reg     <= '0;
            chk_sel_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            row_ext_reg <= row_ext_next;
            col_ext_reg <= col_ext_next;
            clr_reg     <= clr_next;
            idx_reg     <= idx_next;
            chk_sel_reg <= chk_sel_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        sel_reg    <= sel_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        nn_reg     <= nn_next;
        va_reg     <= va_next;
        val_reg    <= val_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    // checks
    `IRT_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready, "transfer accepted while busy")
    `IRT_ASSERT_IMPL(a_ext_bound, aclk, aresetn, 1'b1, (32'(row_ext_reg) <= 32'(EXT_LIMIT)) && (32'(col_ext_reg) <= 32'(EXT_LIMIT)), "extent beyond map depth")
    `IRT_ASSERT_IMPL(a_out_load, aclk, aresetn, m_tvalid && !$past(m_tvalid), $past(state_reg) == irt_pkg::ST_DONE, "result loaded outside done state")

endmodule

[dv/tb_index_remap_table.sv]
// testbench for index_remap_table: row and column remap maps under random stalls
// depends on irt_pkg and the rtl of index_remap_table; answers are predicted
// in the bench from its own copy of both maps and compared per field
`timescale 1ns / 100ps

module tb_index_remap_table;
    import irt_pkg::*;

    localparam int             LIMIT      = 40000;
    localparam int             MAX_SMALL  = 20;
    localparam logic           ROW        = 1'b0;
    localparam logic           COL        = 1'b1;
    localparam logic [2:0]     OP_SPARE6  = 3'd6;
    localparam logic [2:0]     OP_SPARE7  = 3'd7;
    localparam int             IDX_MAX    = IDX_RANGE - 1;

    typedef struct {
        logic [2:0]       opc;
        logic             sel;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] nn;
        bit               drain;
    } table_op_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    table_op_t        table_ops[$];
    res_t             table_answers[$];
    table_op_t        cur_op;
    logic [MAP_W-1:0] remap_tab[2][IDX_RANGE];
    int               map_ext[2];
    int               gen_ext[2];
    int               n_ops;
    int               err_cnt;
    int               cyc_cnt  = 0;
    int               src_gap;
    int               sink_stall;
    int               idle_cnt = 0;

    index_remap_table u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    function automatic bit map_is_perm(logic s);
        bit               seen[IDX_RANGE];
        logic [MAP_W-1:0] v;
        if (map_ext[s] == 0)
            return 1'b0;
        for (int i = 0; i < map_ext[s]; i++) begin
            v = remap_tab[s][i];
            if (v >= map_ext[s] || seen[v])
                return 1'b0;
            seen[v] = 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic res_t table_answer(table_op_t c);
        res_t             r;
        logic [MAP_W-1:0] va;
        logic [MAP_W-1:0] vb;
        int               e;
        r  = '0;
        e  = map_ext[c.sel];
        va = remap_tab[c.sel][c.a];
        vb = remap_tab[c.sel][c.b];
        case (c.opc)
            OP_ADD: begin
                if (c.a >= MAP_DEPTH_DEF) begin
                    r.status = STAT_RANGE;
                end else begin
                    if (c.a >= e)
                        map_ext[c.sel] = int'(c.a) + 1;
                    if (va != UNMAPPED && va != {1'b0, c.nn})
                        r.status = STAT_CONFLICT;
                    else
                        remap_tab[c.sel][c.a] = {1'b0, c.nn};
                end
            end
            OP_LOOKUP: begin
                if (c.a >= e) begin
                    r.status = STAT_RANGE;
                end else if (va == UNMAPPED) begin
                    r.status = STAT_UNMAPPED;
                end else begin
                    r.mapped_value = va[IDX_W-1:0];
                    r.present      = 1'b1;
                end
            end
            OP_HAS: begin
                if (c.a >= e)
                    r.status = STAT_RANGE;
                else
                    r.present = (va != UNMAPPED);
            end
            OP_SWAP: begin
                if (c.a >= e || c.b >= e) begin
                    r.status = STAT_RANGE;
                end else if (va == UNMAPPED || vb == UNMAPPED) begin
                    r.status = STAT_UNMAPPED;
                end else begin
                    remap_tab[c.sel][c.a] = vb;
                    remap_tab[c.sel][c.b] = va;
                end
            end
            OP_OVERWRITE: begin
                if (c.a >= e)
                    r.status = STAT_RANGE;
                else
                    remap_tab[c.sel][c.a] = {1'b0, c.nn};
            end
            OP_CHECK: r.is_permutation = map_is_perm(ROW) && map_is_perm(COL);
            default: ;
        endcase
        return r;
    endfunction

    task automatic push_op(input logic [2:0] opc, input logic sel, input int a, input int b,
                           input int nn);
        table_op_t c;
        c.opc   = opc;
        c.sel   = sel;
        c.a     = IDX_W'(a);
        c.b     = IDX_W'(b);
        c.nn    = IDX_W'(nn);
        c.drain = 1'b0;
        table_ops.insert(table_ops.size(), c);
        n_ops++;
        if (opc == OP_ADD && a + 1 > gen_ext[sel])
            gen_ext[sel] = a + 1;
    endtask

    task automatic push_drain();
        table_op_t c;
        c       = '{default: '0};
        c.drain = 1'b1;
        table_ops.insert(table_ops.size(), c);
    endtask

    // rebuild one map as a random permutation of its (possibly grown) extent
    task automatic rebuild_map(input logic sel);
        int tgt;
        int perm[];
        int j;
        int t;
        tgt = gen_ext[sel] + int'($urandom_range(0, 3));
        if (tgt > MAX_SMALL + 1)
            tgt = gen_ext[sel] > MAX_SMALL + 1 ? gen_ext[sel] : MAX_SMALL + 1;
        if (tgt < 1)
            tgt = 1;
        if (tgt > gen_ext[sel])
            push_op(OP_ADD, sel, tgt - 1, 0, $urandom_range(0, tgt - 1));
        perm = new[tgt];
        for (int i = 0; i < tgt; i++)
            perm[i] = i;
        for (int i = tgt - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            t       = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        for (int i = 0; i < tgt; i++)
            push_op(OP_OVERWRITE, sel, i, 0, perm[i]);
        repeat ($urandom_range(0, 3))
            push_op(OP_SWAP, sel, $urandom_range(0, tgt - 1), $urandom_range(0, tgt - 1), 0);
    endtask

    function automatic int small_idx(logic sel);
        int hi;
        hi = gen_ext[sel] + 1;
        if (hi > MAX_SMALL)
            hi = MAX_SMALL;
        return int'($urandom_range(0, hi));
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    function automatic bit quiet_phase();
        return ((cyc_cnt / 400) % 4) == 1;
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        $display("mismatch on %s: got %0d expected %0d at %0t", what, got_v, want_v,
                 $realtime);
        err_cnt++;
    endtask

    // driver
    always @(posedge aclk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap  = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                table_answers.insert(table_answers.size(), table_answer(cur_op));
                src_gap = quiet_phase() ? 0 : pick_gap();
            end
            if (!(s_tvalid && !s_tready)) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else begin
                    while (table_ops.size() > 0 && table_ops[0].drain &&
                           table_answers.size() == 0)
                        void'(table_ops.pop_front());
                    if (table_ops.size() > 0 && !table_ops[0].drain) begin
                        cur_op = table_ops.pop_front();
                        s_tvalid <= 1'b1;
                        s_tdata  <= {7'b0, cur_op.nn, cur_op.b, cur_op.a, cur_op.opc};
                        s_tuser  <= cur_op.sel;
                    end else begin
                        s_tvalid <= 1'b0;
                    end
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            sink_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata[13:0]);
                if (table_answers.size() == 0) begin
                    report_mismatch("unexpected transfer", int'(m_tdata), 0);
                end else begin
                    want = table_answers.pop_front();
                    if (got.mapped_value !== want.mapped_value)
                        report_mismatch("mapped_value", int'(got.mapped_value),
                                        int'(want.mapped_value));
                    if (got.present !== want.present)
                        report_mismatch("present", int'(got.present), int'(want.present));
                    if (got.status !== want.status)
                        report_mismatch("status", int'(got.status), int'(want.status));
                    if (got.is_permutation !== want.is_permutation)
                        report_mismatch("is_permutation", int'(got.is_permutation),
                                        int'(want.is_permutation));
                    if (m_tdata[M_TDATA_W-1:14] !== '0)
                        report_mismatch("padding", int'(m_tdata[M_TDATA_W-1:14]), 0);
                end
            end
            if (sink_stall > 0) begin
                sink_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready   <= 1'b1;
                sink_stall = quiet_phase() ? 0 : pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        int r;
        logic s;
        n_ops    = 0;
        err_cnt  = 0;
        for (int i = 0; i < IDX_RANGE; i++) begin
            remap_tab[ROW][i] = UNMAPPED;
            remap_tab[COL][i] = UNMAPPED;
        end
        map_ext = '{0, 0};
        gen_ext = '{0, 0};

        // directed: empty maps, faults, conflicts, a valid pair of permutations
        push_op(OP_CHECK, ROW, 0, 0, 0);
        push_op(OP_LOOKUP, ROW, 0, 0, 0);
        push_op(OP_HAS, COL, 0, 0, 0);
        push_op(OP_SWAP, ROW, 0, 0, 0);
        push_op(OP_OVERWRITE, ROW, 0, 0, 0);
        push_op(OP_ADD, ROW, 2, 0, 0);
        push_op(OP_HAS, ROW, 0, 0, 0);
        push_op(OP_LOOKUP, ROW, 1, 0, 0);
        push_op(OP_SWAP, ROW, 0, 2, 0);
        push_op(OP_ADD, ROW, 0, 0, 2);
        push_op(OP_ADD, ROW, 0, 0, 2);
        push_op(OP_ADD, ROW, 0, 0, 1);
        push_op(OP_ADD, ROW, 1, 0, 1);
        push_op(OP_SWAP, ROW, 0, 2, 0);
        push_op(OP_LOOKUP, ROW, 0, 0, 0);
        push_op(OP_ADD, COL, 1, 0, IDX_MAX);
        push_op(OP_OVERWRITE, COL, 1, 0, 0);
        push_op(OP_ADD, COL, 0, 0, 1);
        push_op(OP_CHECK, COL, 0, 0, 0);
        push_drain();
        push_op(OP_SWAP, COL, 0, IDX_MAX, 0);
        push_op(OP_OVERWRITE, ROW, 2, 0, IDX_MAX);
        push_op(OP_CHECK, ROW, 0, 0, 0);
        push_op(OP_SPARE6, COL, IDX_MAX, IDX_MAX, IDX_MAX);
        push_op(OP_SPARE7, COL, IDX_MAX, IDX_MAX, IDX_MAX);

        // random part, small extents
        while (n_ops < 770) begin
            r = $urandom_range(0, 99);
            s = 1'($urandom_range(0, 1));
            if (r < 12) begin
                rebuild_map(s);
                if ($urandom_range(0, 1))
                    rebuild_map(!s);
                push_op(OP_CHECK, s, 0, 0, 0);
            end else if (r < 45) begin
                push_op($urandom_range(0, 1) ? OP_LOOKUP : OP_HAS, s, small_idx(s), 0, 0);
            end else if (r < 58) begin
                push_op(OP_SWAP, s, small_idx(s), small_idx(s), 0);
            end else if (r < 68) begin
                push_op(OP_ADD, s, small_idx(s), 0,
                        $urandom_range(0, 3) == 0 ? $urandom_range(0, IDX_MAX)
                                                  : $urandom_range(0, MAX_SMALL));
            end else if (r < 76) begin
                push_op(OP_OVERWRITE, s, small_idx(s), 0, $urandom_range(0, MAX_SMALL + 2));
            end else if (r < 83) begin
                push_op(OP_CHECK, s, $urandom_range(0, IDX_MAX), $urandom_range(0, IDX_MAX),
                        $urandom_range(0, IDX_MAX));
            end else if (r < 96) begin
                push_op(3'($urandom_range(OP_LOOKUP, OP_SPARE7)), s,
                        $urandom_range(0, IDX_MAX), $urandom_range(0, IDX_MAX),
                        $urandom_range(0, IDX_MAX));
            end else begin
                push_drain();
            end
        end

        // full-size extents at the end
        push_op(OP_ADD, ROW, IDX_MAX, 0, IDX_MAX);
        push_op(OP_LOOKUP, ROW, IDX_MAX, 0, 0);
        push_op(OP_HAS, ROW, IDX_MAX - 1, 0, 0);
        push_op(OP_SWAP, ROW, IDX_MAX, 0, 0);
        push_op(OP_SWAP, ROW, 0, IDX_MAX, 0);
        push_op(OP_OVERWRITE, ROW, IDX_MAX, 0, 0);
        push_op(OP_ADD, COL, IDX_MAX, 0, 512);
        push_op(OP_SWAP, COL, IDX_MAX, IDX_MAX - 1, 0);
        push_op(OP_LOOKUP, COL, IDX_MAX, 0, 0);
        push_op(OP_HAS, COL, IDX_MAX, 0, 0);
        push_op(OP_CHECK, ROW, 0, 0, 0);
        push_op(OP_LOOKUP, COL, 0, 0, 0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        do
            @(negedge aclk);
        while (table_ops.size() > 0 || s_tvalid || table_answers.size() > 0);
        repeat (64) @(posedge aclk);

        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
